@@ rtl/kpg_pkg.sv @@
`default_nettype none
package kpg_pkg;
	localparam int MAX_SYMBOLS_DEF = 32;
	localparam int ACT_W = 2;
	localparam int SYM_W = 8;
	localparam int PL_W = 6;

	typedef logic [ACT_W-1:0] action_t;
	typedef logic [SYM_W-1:0] symbol_t;
	typedef logic [PL_W-1:0] plen_t;

	localparam action_t ACT_LOAD = 2'd0;
	localparam action_t ACT_NEXT = 2'd1;
	localparam action_t ACT_CLEAR = 2'd2;
	localparam action_t ACT_RSVD = 2'd3;

	typedef enum logic [1:0] {
		PH_LOADING = 2'd0,
		PH_RUNNING = 2'd1,
		PH_DONE = 2'd2
	} phase_t;
endpackage
`default_nettype wire

@@ rtl/kpg_if.sv @@
`default_nettype none
interface kpg_req_if;
	logic valid;
	logic ready;
	kpg_pkg::action_t action;
	kpg_pkg::symbol_t symbol_in;
	modport source(output valid, action, symbol_in, input ready);
	modport sink(input valid, action, symbol_in, output ready);
endinterface

interface kpg_rsp_if;
	logic valid;
	logic ready;
	kpg_pkg::symbol_t symbol_out;
	logic last_of_run;
	logic finished;
	modport source(output valid, symbol_out, last_of_run, finished, input ready);
	modport sink(input valid, symbol_out, last_of_run, finished, output ready);
endinterface

interface kpg_cfg_if;
	logic valid;
	logic ready;
	kpg_pkg::plen_t perm_length;
	modport source(output valid, perm_length, input ready);
	modport sink(input valid, perm_length, output ready);
endinterface
`default_nettype wire

@@ rtl/k_permutation_generator_core.sv @@
`default_nettype none
// k-permutation generator. Load beats append symbols to a queue (ignored when
// full or once a run has started); each next beat emits one arrangement of k
// symbols as k output beats, the last flagged, or a single finished beat when
// none remain. Clear beats restart everything but perm_length. Load, clear and
// unused beats are handled directly in the idle state. A next beat is worked by
// one sequencer that walks the queue one entry at a time: entering a level
// copies the queue into the single-port snapshot RAM, and each level check
// takes each snapshot entry through a registered RAM read, then compares it
// with the live queue entry; output beats wait for a free output slot. Input
// is not ready meanwhile.
module k_permutation_generator_core #(
	parameter int MAX_SYMBOLS = kpg_pkg::MAX_SYMBOLS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	kpg_req_if.sink req,
	kpg_rsp_if.source rsp,
	kpg_cfg_if.sink cfg
);
	localparam int AW = $clog2(MAX_SYMBOLS);
	localparam int CW = $clog2(MAX_SYMBOLS + 1);
	localparam int MW = $clog2(MAX_SYMBOLS * MAX_SYMBOLS);
	localparam int KW = (CW > kpg_pkg::PL_W) ? CW : kpg_pkg::PL_W;
	localparam logic [CW-1:0] FULL = CW'(MAX_SYMBOLS);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_DESC  = 7'b0000010,
		ST_SNAP  = 7'b0000100,
		ST_CHK   = 7'b0001000,
		ST_CMP   = 7'b0010000,
		ST_EMIT  = 7'b0100000,
		ST_FIN   = 7'b1000000
	} state_t;

	state_t state_q;
	kpg_pkg::phase_t phase_q;
	kpg_pkg::plen_t plen_q;
	kpg_pkg::symbol_t q_q [MAX_SYMBOLS];
	kpg_pkg::symbol_t ps_q [MAX_SYMBOLS];
	logic [CW-1:0] slen_q [MAX_SYMBOLS];
	kpg_pkg::symbol_t snap_mem [MAX_SYMBOLS*MAX_SYMBOLS];
	kpg_pkg::symbol_t rd_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] cnt_q, pc_q, lvl_q, k_q, j_q;
	logic out_v_q, last_q, fin_q;
	kpg_pkg::symbol_t sym_q;

	function automatic logic [AW-1:0] wrap(input logic [AW:0] v);
		logic [AW:0] r;
		r = (v >= (AW+1)'(MAX_SYMBOLS)) ? v - (AW+1)'(MAX_SYMBOLS) : v;
		return r[AW-1:0];
	endfunction

	logic slot_free;
	logic [AW-1:0] tail_idx, jq_idx, lvl_idx;
	logic [MW-1:0] maddr;
	kpg_pkg::symbol_t front, top;
	logic [KW-1:0] pl_x, cnt_x;
	logic [CW-1:0] k_new;

	assign slot_free = !out_v_q || rsp.ready;
	assign tail_idx = wrap({1'b0, head_q} + (AW+1)'(cnt_q));
	assign jq_idx = wrap({1'b0, head_q} + (AW+1)'(j_q));
	assign lvl_idx = lvl_q[AW-1:0];
	assign maddr = MW'(lvl_idx) * MW'(MAX_SYMBOLS) + MW'(j_q);
	assign front = (cnt_q == '0) ? '0 : q_q[head_q];
	assign top = (pc_q == '0) ? '0 : ps_q[AW'(pc_q - 1'b1)];
	assign pl_x = KW'(plen_q);
	assign cnt_x = KW'(cnt_q);
	assign k_new = (pl_x == '0 || pl_x > cnt_x) ? cnt_q : CW'(pl_x);

	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = out_v_q;
	assign rsp.symbol_out = sym_q;
	assign rsp.last_of_run = last_q;
	assign rsp.finished = fin_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_SNAP && j_q < cnt_q) begin
			snap_mem[maddr] <= q_q[jq_idx];
		end
		rd_q <= snap_mem[maddr];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SNAP && j_q >= cnt_q) begin
			slen_q[lvl_idx] <= cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q <= '0;
		end else if (cfg.valid) begin
			plen_q <= cfg.perm_length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (slot_free) begin
			out_v_q <= (state_q == ST_EMIT) || (state_q == ST_FIN);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= kpg_pkg::PH_LOADING;
			head_q <= '0;
			cnt_q <= '0;
			pc_q <= '0;
			lvl_q <= '0;
			k_q <= '0;
			j_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						case (req.action)
							kpg_pkg::ACT_LOAD: begin
								if (phase_q == kpg_pkg::PH_LOADING && cnt_q < FULL) begin
									q_q[tail_idx] <= req.symbol_in;
									cnt_q <= cnt_q + 1'b1;
								end
							end
							kpg_pkg::ACT_NEXT: begin
								if (phase_q == kpg_pkg::PH_DONE) begin
									state_q <= ST_FIN;
								end else if (phase_q == kpg_pkg::PH_LOADING) begin
									k_q <= k_new;
									lvl_q <= '0;
									state_q <= (k_new == '0) ? ST_FIN : ST_DESC;
								end else begin
									if (pc_q != '0) begin
										pc_q <= pc_q - 1'b1;
									end
									if (cnt_q < FULL) begin
										q_q[tail_idx] <= top;
										cnt_q <= cnt_q + 1'b1;
									end
									lvl_q <= k_q - 1'b1;
									j_q <= '0;
									state_q <= ST_CHK;
								end
							end
							kpg_pkg::ACT_CLEAR: begin
								phase_q <= kpg_pkg::PH_LOADING;
								head_q <= '0;
								cnt_q <= '0;
								pc_q <= '0;
								lvl_q <= '0;
								k_q <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_DESC: begin
					j_q <= '0;
					if (lvl_q < k_q) begin
						state_q <= ST_SNAP;
					end else begin
						phase_q <= kpg_pkg::PH_RUNNING;
						state_q <= ST_EMIT;
					end
				end
				ST_SNAP: begin
					if (j_q < cnt_q) begin
						j_q <= j_q + 1'b1;
					end else begin
						if (pc_q < FULL) begin
							ps_q[AW'(pc_q)] <= front;
							pc_q <= pc_q + 1'b1;
						end
						if (cnt_q != '0) begin
							head_q <= wrap({1'b0, head_q} + 1'b1);
							cnt_q <= cnt_q - 1'b1;
						end
						lvl_q <= lvl_q + 1'b1;
						state_q <= ST_DESC;
					end
				end
				ST_CHK: begin
					if (slen_q[lvl_idx] != cnt_q) begin
						if (pc_q < FULL) begin
							ps_q[AW'(pc_q)] <= front;
							pc_q <= pc_q + 1'b1;
						end
						if (cnt_q != '0) begin
							head_q <= wrap({1'b0, head_q} + 1'b1);
							cnt_q <= cnt_q - 1'b1;
						end
						lvl_q <= lvl_q + 1'b1;
						state_q <= ST_DESC;
					end else if (j_q == cnt_q) begin
						if (lvl_q == '0) begin
							state_q <= ST_FIN;
						end else begin
							if (pc_q != '0) begin
								pc_q <= pc_q - 1'b1;
							end
							if (cnt_q < FULL) begin
								q_q[tail_idx] <= top;
								cnt_q <= cnt_q + 1'b1;
							end
							lvl_q <= lvl_q - 1'b1;
							j_q <= '0;
						end
					end else begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (rd_q != q_q[jq_idx]) begin
						if (pc_q < FULL) begin
							ps_q[AW'(pc_q)] <= front;
							pc_q <= pc_q + 1'b1;
						end
						if (cnt_q != '0) begin
							head_q <= wrap({1'b0, head_q} + 1'b1);
							cnt_q <= cnt_q - 1'b1;
						end
						lvl_q <= lvl_q + 1'b1;
						state_q <= ST_DESC;
					end else begin
						j_q <= j_q + 1'b1;
						state_q <= ST_CHK;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						sym_q <= ps_q[AW'(j_q)];
						last_q <= (j_q + 1'b1 == pc_q);
						fin_q <= 1'b0;
						j_q <= j_q + 1'b1;
						if (j_q + 1'b1 >= pc_q) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_FIN: begin
					if (slot_free) begin
						sym_q <= '0;
						last_q <= 1'b1;
						fin_q <= 1'b1;
						phase_q <= kpg_pkg::PH_DONE;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_conserve: assert property (@(posedge clk) disable iff (!arst_n)
		(CW+1)'(cnt_q) + (CW+1)'(pc_q) <= (CW+1)'(MAX_SYMBOLS))
		else $error("queue plus stack exceed capacity");
	a_lvl: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == kpg_pkg::PH_RUNNING && state_q == ST_IDLE |-> pc_q == k_q)
		else $error("placed depth differs from k between requests");
	a_fin: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && fin_q |-> sym_q == '0 && last_q)
		else $error("finished beat malformed");
	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> j_q < pc_q)
		else $error("emit index past stack");
endmodule
`default_nettype wire
